### hdl/vlod_pkg.sv
// Package: word types, status and error codes, and decoder phase for the opcode decoder.
package vlod_pkg;

  // Input word: one bytecode byte, or a fetch fault.
  typedef struct packed {
    logic [7:0] code_byte;
    logic       fetch_fault;
  } byte_t;

  // Result word.
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] opcode;
    logic [2:0]  error_kind;
    logic [15:0] error_detail;
  } result_t;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ILLEGAL = 2'd1;
  localparam logic [1:0] ST_FAULT   = 2'd2;

  // Error kinds
  localparam logic [2:0] ERR_NONE           = 3'd0;
  localparam logic [2:0] ERR_STRAY_CONT     = 3'd1;
  localparam logic [2:0] ERR_TWO_LAST       = 3'd2;
  localparam logic [2:0] ERR_TWO_OVERLONG   = 3'd3;
  localparam logic [2:0] ERR_THREE_MID      = 3'd4;
  localparam logic [2:0] ERR_THREE_LAST     = 3'd5;
  localparam logic [2:0] ERR_THREE_OVERLONG = 3'd6;
  localparam logic [2:0] ERR_BAD_LEAD       = 3'd7;

  // Decoder phase
  typedef enum logic [3:0] {
    PH_LEAD       = 4'b0001,
    PH_TWO_LAST   = 4'b0010,
    PH_THREE_MID  = 4'b0100,
    PH_THREE_LAST = 4'b1000
  } phase_t;

  // Decode outcome for one byte: optional result plus next decoder state.
  typedef struct packed {
    logic       emit;
    result_t    result;
    phase_t     phase_next;
    logic [7:0] lead_next;
    logic [7:0] middle_next;
  } decode_t;

endpackage

### hdl/variable_length_opcode_decoder_top.sv
// Top level of the variable-length opcode decoder: input register, decode, result register.
// A byte is held in the input register, decoded, then its result word is held in the result register.
// Throughput: one byte per cycle unless stalled; the decode is a handful of compares between the registers.
// Bytes that open or continue an unfinished form give no result word.
// Result back-pressure stalls the input register only when its byte would give a result.
// Reset (rst, synchronous, active high): both valid flags clear, phase returns to lead.
module variable_length_opcode_decoder_top (
  input  logic              clk,
  input  logic              rst,
  // byte channel
  input  logic              byte_valid,
  output logic              byte_stall,
  input  vlod_pkg::byte_t   byte_word,
  // result channel
  output logic              result_valid,
  input  logic              result_stall,
  output vlod_pkg::result_t result_word
);

  // Input register
  logic              s1_valid;
  vlod_pkg::byte_t   s1_word;

  // Decoder state
  vlod_pkg::phase_t  phase;
  logic [7:0]        lead_byte;
  logic [7:0]        middle_byte;

  vlod_pkg::decode_t dec;
  logic              out_free;
  logic              s1_go;
  logic              in_take;

  vlod_decode u_decode (
    .phase       (phase),
    .lead_byte   (lead_byte),
    .middle_byte (middle_byte),
    .word        (s1_word),
    .dec         (dec)
  );

  // Result register can take a word when empty or being drained this cycle.
  assign out_free = !result_valid || !result_stall;
  // The held byte moves on unless it makes a result with nowhere to go.
  assign s1_go    = s1_valid && (!dec.emit || out_free);
  assign byte_stall = s1_valid && !s1_go;
  assign in_take  = byte_valid && !byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
    end
    if (in_take) begin
      s1_word <= byte_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= vlod_pkg::PH_LEAD;
      lead_byte   <= 8'd0;
      middle_byte <= 8'd0;
    end else if (s1_go) begin
      phase       <= dec.phase_next;
      lead_byte   <= dec.lead_next;
      middle_byte <= dec.middle_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      if (s1_go && dec.emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
    if (s1_go && dec.emit) begin
      result_word <= dec.result;
    end
  end

`ifndef SYNTHESIS
  // Every emitted result sends the decoder back to the lead phase.
  a_emit_to_lead: assert property (@(posedge clk) disable iff (rst)
    s1_go && dec.emit |=> phase == vlod_pkg::PH_LEAD)
    else $error("phase not lead after result");

  // A good opcode carries no error information.
  a_ok_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_word.status == vlod_pkg::ST_OK |->
      result_word.error_kind == vlod_pkg::ERR_NONE && result_word.error_detail == 16'd0)
    else $error("ok result with error fields");

  // An illegal encoding names a check and no opcode.
  a_illegal_kind: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_word.status == vlod_pkg::ST_ILLEGAL |->
      result_word.error_kind != vlod_pkg::ERR_NONE && result_word.opcode == 16'd0)
    else $error("illegal result without kind");

  // A fetch fault leaves every other field zero.
  a_fault_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_word.status == vlod_pkg::ST_FAULT |->
      result_word.opcode == 16'd0 && result_word.error_kind == vlod_pkg::ERR_NONE &&
      result_word.error_detail == 16'd0)
    else $error("fault result with nonzero fields");

  // Continuing phases are reached only by consuming a byte.
  a_phase_moves: assert property (@(posedge clk) disable iff (rst)
    !s1_go |=> $stable(phase))
    else $error("phase changed without a byte");
`endif

endmodule

### hdl/vlod_decode.sv
// Combinational decode of one byte against the current decoder state.
module vlod_decode (
  input  vlod_pkg::phase_t  phase,
  input  logic [7:0]        lead_byte,
  input  logic [7:0]        middle_byte,
  input  vlod_pkg::byte_t   word,
  output vlod_pkg::decode_t dec
);

  logic [7:0]  b;
  logic        is_cont;
  logic [10:0] val2;
  logic [15:0] val3;

  assign b       = word.code_byte;
  assign is_cont = (b[7:6] == 2'b10);
  assign val2    = {lead_byte[4:0], b[5:0]};
  assign val3    = {lead_byte[3:0], middle_byte[5:0], b[5:0]};

  always_comb begin
    dec.emit                = 1'b0;
    dec.result.status       = vlod_pkg::ST_OK;
    dec.result.opcode       = 16'd0;
    dec.result.error_kind   = vlod_pkg::ERR_NONE;
    dec.result.error_detail = 16'd0;
    dec.phase_next          = vlod_pkg::PH_LEAD;
    dec.lead_next           = lead_byte;
    dec.middle_next         = middle_byte;

    if (word.fetch_fault) begin
      dec.emit          = 1'b1;
      dec.result.status = vlod_pkg::ST_FAULT;
    end else begin
      unique case (phase)
        vlod_pkg::PH_LEAD: begin
          priority if (!b[7]) begin
            dec.emit              = 1'b1;
            dec.result.opcode     = {8'd0, b};
          end else if (is_cont) begin
            dec.emit                = 1'b1;
            dec.result.status       = vlod_pkg::ST_ILLEGAL;
            dec.result.error_kind   = vlod_pkg::ERR_STRAY_CONT;
            dec.result.error_detail = {8'd0, b};
          end else if (b[7:5] == 3'b110) begin
            dec.lead_next  = b;
            dec.phase_next = vlod_pkg::PH_TWO_LAST;
          end else if (b[7:4] == 4'b1110) begin
            dec.lead_next  = b;
            dec.phase_next = vlod_pkg::PH_THREE_MID;
          end else begin
            dec.emit                = 1'b1;
            dec.result.status       = vlod_pkg::ST_ILLEGAL;
            dec.result.error_kind   = vlod_pkg::ERR_BAD_LEAD;
            dec.result.error_detail = {8'd0, b};
          end
        end
        vlod_pkg::PH_TWO_LAST: begin
          dec.emit = 1'b1;
          priority if (!is_cont) begin
            dec.result.status       = vlod_pkg::ST_ILLEGAL;
            dec.result.error_kind   = vlod_pkg::ERR_TWO_LAST;
            dec.result.error_detail = {8'd0, lead_byte};
          end else if (lead_byte[4:1] == 4'd0) begin
            // overlong: value below 128
            dec.result.status       = vlod_pkg::ST_ILLEGAL;
            dec.result.error_kind   = vlod_pkg::ERR_TWO_OVERLONG;
            dec.result.error_detail = {5'd0, val2};
          end else begin
            dec.result.opcode = {5'd0, val2};
          end
        end
        vlod_pkg::PH_THREE_MID: begin
          if (!is_cont) begin
            dec.emit                = 1'b1;
            dec.result.status       = vlod_pkg::ST_ILLEGAL;
            dec.result.error_kind   = vlod_pkg::ERR_THREE_MID;
            dec.result.error_detail = {8'd0, b};
          end else begin
            dec.middle_next = b;
            dec.phase_next  = vlod_pkg::PH_THREE_LAST;
          end
        end
        vlod_pkg::PH_THREE_LAST: begin
          dec.emit = 1'b1;
          priority if (!is_cont) begin
            dec.result.status       = vlod_pkg::ST_ILLEGAL;
            dec.result.error_kind   = vlod_pkg::ERR_THREE_LAST;
            dec.result.error_detail = {8'd0, middle_byte};
          end else if (val3[15:11] == 5'd0) begin
            // overlong: value fits in 11 bits
            dec.result.status       = vlod_pkg::ST_ILLEGAL;
            dec.result.error_kind   = vlod_pkg::ERR_THREE_OVERLONG;
            dec.result.error_detail = val3;
          end else begin
            dec.result.opcode = val3;
          end
        end
        default: begin
          dec.phase_next = vlod_pkg::PH_LEAD;
        end
      endcase
    end
  end

endmodule

### test/variable_length_opcode_decoder_top_tb.sv
// Testbench for the variable-length opcode decoder: directed and random byte streams.
`timescale 1ns / 100ps

module variable_length_opcode_decoder_top_tb;

  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 4;
  localparam int QUIET_LIMIT    = 1000;  // cycles with no word moving on either side
  localparam int SETTLE_CYCLES  = 10;    // tail after the last result
  localparam int MAX_REPORTS    = 10;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              byte_valid = 1'b0;
  logic              byte_stall;
  vlod_pkg::byte_t   byte_word = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  vlod_pkg::result_t result_word;

  // Decoder state as predicted from the accepted byte words
  vlod_pkg::phase_t dec_phase = vlod_pkg::PH_LEAD;
  logic [7:0]       form_lead = 8'h00;
  logic [7:0]       form_middle = 8'h00;

  vlod_pkg::result_t expected_words[$];
  int      error_count = 0;
  int      words_sent = 0;
  int      quiet_cycles = 0;

  // Idling knobs, flipped by the test tasks
  bit      sender_gaps = 1'b0;
  bit      receiver_stalls = 1'b0;
  int      stall_left = 0;

  variable_length_opcode_decoder_top DUT (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_word    (byte_word),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_word  (result_word)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Mostly zero, sometimes a few cycles, rarely a long hold.
  function automatic int pick_idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 99) return $urandom_range(4, 12);
    return $urandom_range(13, 40);
  endfunction

  function automatic bit is_cont(logic [7:0] b);
    return b[7:6] == 2'b10;
  endfunction

  // Predicted decode of one accepted byte word. Pushes the result word it
  // gives, if any; bytes that open or extend a form only move the phase and keep the byte.
  task automatic decode_byte(input vlod_pkg::byte_t w);
    vlod_pkg::result_t r;
    logic [15:0]       val;
    logic [7:0]        b;
    bit                gives;
    r     = '0;
    gives = 1'b1;
    b     = w.code_byte;
    if (w.fetch_fault) begin
      // code byte is don't-care on a fault, any phase
      r.status = vlod_pkg::ST_FAULT;
    end else begin
      case (dec_phase)
        vlod_pkg::PH_LEAD: begin
          if (!b[7]) begin
            r.status = vlod_pkg::ST_OK;
            r.opcode = {8'h00, b};
          end else if (is_cont(b)) begin
            r.status       = vlod_pkg::ST_ILLEGAL;
            r.error_kind   = vlod_pkg::ERR_STRAY_CONT;
            r.error_detail = {8'h00, b};
          end else if (b[7:5] == 3'b110) begin
            form_lead = b;
            dec_phase = vlod_pkg::PH_TWO_LAST;
            gives     = 1'b0;
          end else if (b[7:4] == 4'b1110) begin
            form_lead = b;
            dec_phase = vlod_pkg::PH_THREE_MID;
            gives     = 1'b0;
          end else begin
            r.status       = vlod_pkg::ST_ILLEGAL;
            r.error_kind   = vlod_pkg::ERR_BAD_LEAD;
            r.error_detail = {8'h00, b};
          end
        end
        vlod_pkg::PH_TWO_LAST: begin
          val = {5'b0, form_lead[4:0], b[5:0]};
          r.status = vlod_pkg::ST_ILLEGAL;
          if (!is_cont(b)) begin
            r.error_kind   = vlod_pkg::ERR_TWO_LAST;
            r.error_detail = {8'h00, form_lead};
          end else if (val < 16'd128) begin
            r.error_kind   = vlod_pkg::ERR_TWO_OVERLONG;
            r.error_detail = val;
          end else begin
            r.status = vlod_pkg::ST_OK;
            r.opcode = val;
          end
        end
        vlod_pkg::PH_THREE_MID: begin
          if (!is_cont(b)) begin
            r.status       = vlod_pkg::ST_ILLEGAL;
            r.error_kind   = vlod_pkg::ERR_THREE_MID;
            r.error_detail = {8'h00, b};
          end else begin
            form_middle = b;
            dec_phase   = vlod_pkg::PH_THREE_LAST;
            gives       = 1'b0;
          end
        end
        default: begin
          val = {form_lead[3:0], form_middle[5:0], b[5:0]};
          r.status = vlod_pkg::ST_ILLEGAL;
          if (!is_cont(b)) begin
            r.error_kind   = vlod_pkg::ERR_THREE_LAST;
            r.error_detail = {8'h00, form_middle};
          end else if (val <= 16'h07FF) begin
            r.error_kind   = vlod_pkg::ERR_THREE_OVERLONG;
            r.error_detail = val;
          end else begin
            r.status = vlod_pkg::ST_OK;
            r.opcode = val;
          end
        end
      endcase
    end
    if (gives) begin
      expected_words.push_back(r);
      dec_phase = vlod_pkg::PH_LEAD;
    end
  endtask

  // Send one byte word. Valid stays high across back-to-back words; a gap
  // drops it first. Stall is sampled as it stood just before each edge.
  task automatic send_byte(input logic [7:0] code, input logic fault);
    vlod_pkg::byte_t w;
    int              gap;
    w.code_byte   = code;
    w.fetch_fault = fault;
    gap = sender_gaps ? pick_idle_len() : 0;
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_word  <= w;
    do @(posedge clk); while (byte_stall);
    decode_byte(w);
    words_sent++;
  endtask

  // Drop valid and hold off until every predicted result word is back.
  task automatic wait_drained();
    byte_valid <= 1'b0;
    do @(posedge clk); while (expected_words.size() != 0);
  endtask

  // Receiver side: random stall bursts when enabled.
  always @(posedge clk) begin
    if (rst || !receiver_stalls) begin
      result_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      result_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      result_stall <= 1'b0;
      stall_left = pick_idle_len();
    end
  end

  // Result checker: each accepted result word against the oldest prediction.
  always @(posedge clk) begin : check_results
    vlod_pkg::result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_words.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: unexpected word: status %0d opcode %h kind %0d detail %h",
                   $time, result_word.status, result_word.opcode,
                   result_word.error_kind, result_word.error_detail);
      end else begin
        want = expected_words.pop_front();
        if (result_word.status !== want.status || result_word.opcode !== want.opcode ||
            result_word.error_kind !== want.error_kind ||
            result_word.error_detail !== want.error_detail) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: exp st %0d op %h kind %0d det %h, got st %0d op %h kind %0d det %h",
                     $time, want.status, want.opcode, want.error_kind, want.error_detail,
                     result_word.status, result_word.opcode, result_word.error_kind,
                     result_word.error_detail);
        end
      end
    end
  end

  // Watchdog: ends the run if no word moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (byte_valid && !byte_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: watchdog timeout", $time);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------

  // One-byte opcodes at both ends of the range.
  task automatic test_one_byte();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
  endtask

  // Two-byte forms: smallest and largest legal, overlong edge, bad last byte.
  task automatic test_two_byte();
    send_byte(8'hC2, 1'b0); send_byte(8'h80, 1'b0);  // 0x080
    send_byte(8'hDF, 1'b0); send_byte(8'hBF, 1'b0);  // 0x7FF
    send_byte(8'hC1, 1'b0); send_byte(8'hBF, 1'b0);  // 127, overlong
    send_byte(8'hC3, 1'b0); send_byte(8'h41, 1'b0);  // non-continuation last byte
  endtask

  // Three-byte forms: smallest and largest legal, overlong edge,
  // bad middle byte, bad last byte.
  task automatic test_three_byte();
    send_byte(8'hE0, 1'b0); send_byte(8'hA0, 1'b0); send_byte(8'h80, 1'b0);  // 0x0800
    send_byte(8'hEF, 1'b0); send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b0);  // 0xFFFF
    send_byte(8'hE0, 1'b0); send_byte(8'h9F, 1'b0); send_byte(8'hBF, 1'b0);  // 0x7FF overlong
    send_byte(8'hE5, 1'b0); send_byte(8'h7F, 1'b0);                          // bad middle
    send_byte(8'hE5, 1'b0); send_byte(8'hBF, 1'b0); send_byte(8'hC0, 1'b0);  // bad last
  endtask

  // Stray continuation as lead, and a 1111xxxx lead.
  task automatic test_bad_lead();
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
  endtask

  // Fetch fault in every phase; the code byte is ignored.
  task automatic test_fetch_fault();
    send_byte(8'hFF, 1'b1);                                                  // lead phase
    send_byte(8'hC5, 1'b0); send_byte(8'h85, 1'b1);                          // two-byte last
    send_byte(8'hE5, 1'b0); send_byte(8'h00, 1'b1);                          // three-byte middle
    send_byte(8'hE5, 1'b0); send_byte(8'h85, 1'b0); send_byte(8'hAA, 1'b1);  // three-byte last
  endtask

  // ---------------------------------------------------------------------
  // Random streams
  // ---------------------------------------------------------------------

  // Mostly well-formed opcodes with random content, plus broken forms,
  // raw noise and faults.
  task automatic run_random_stream(input int n_words);
    int start;
    int pick;
    start = words_sent;
    while (words_sent - start < n_words) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        send_byte(8'($urandom_range(0, 127)), 1'b0);
      end else if (pick < 40) begin
        send_byte(8'hC0 | 8'($urandom_range(0, 31)), 1'b0);
        send_byte(8'h80 | 8'($urandom_range(0, 63)), 1'b0);
      end else if (pick < 65) begin
        send_byte(8'hE0 | 8'($urandom_range(0, 15)), 1'b0);
        send_byte(8'h80 | 8'($urandom_range(0, 63)), 1'b0);
        send_byte(8'h80 | 8'($urandom_range(0, 63)), 1'b0);
      end else if (pick < 75) begin
        // two-byte lead followed by anything
        send_byte(8'hC0 | 8'($urandom_range(0, 31)), 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b0);
      end else if (pick < 85) begin
        // three-byte lead followed by anything
        send_byte(8'hE0 | 8'($urandom_range(0, 15)), 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b0);
      end else if (pick < 92) begin
        send_byte(8'($urandom_range(0, 255)), 1'b0);
      end else if (pick < 97) begin
        // fault partway into whatever the lead opened
        send_byte(8'($urandom_range(0, 255)), 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        send_byte(8'($urandom_range(0, 255)), 1'b1);
      end
    end
  endtask

  // Full rate on both sides.
  task automatic test_random_full_rate();
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    run_random_stream(150);
  endtask

  // Sender at full rate against receiver back-pressure.
  task automatic test_random_backpressure();
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b1;
    run_random_stream(100);
  endtask

  // Sender holds off until the pipeline is empty, then resumes.
  task automatic test_drain_pause();
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
    run_random_stream(50);
    wait_drained();
    run_random_stream(50);
  endtask

  // Random idling on both sides.
  task automatic test_random_idling();
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
    run_random_stream(250);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed part runs with idling on so gaps land mid-form
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
    test_one_byte();
    test_two_byte();
    test_three_byte();
    test_bad_lead();
    test_fetch_fault();

    test_random_full_rate();
    test_random_backpressure();
    test_drain_pause();
    test_random_idling();

    // wind down: wait out every predicted word, then the pipeline tail
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (error_count == 0 && expected_words.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
